// ===== hdl/rwct_pkg.sv =====
// Package: shared types, constants and codes for the raycast wall column texel block.
`default_nettype none

package rwct_pkg;

  localparam int SCREEN_HEIGHT = 512;
  localparam int HALF_H        = SCREEN_HEIGHT / 2;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int LH_W    = 16;
  localparam int TX_W    = 10;
  localparam int TY_W    = 10;
  localparam int COLOR_W = 32;
  localparam int TH_W    = 11;
  localparam int CFG_IW  = 2;

  // Slice bounds and row positions; holds HALF_H plus half of the widest slice.
  localparam int POS_W  = 17;
  // Positive texture row numerator, always below twice the slice height.
  localparam int NUM_W  = LH_W + 1;
  localparam int PROD_W = NUM_W + TH_W;
  // Quotient bits: the texture row stays below texture_height.
  localparam int QW     = TH_W;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);

  localparam logic [TY_W-1:0] TY_MAX = {TY_W{1'b1}};

  // region codes
  localparam logic [1:0] REGION_CEIL  = 2'd0;
  localparam logic [1:0] REGION_WALL  = 2'd1;
  localparam logic [1:0] REGION_FLOOR = 2'd2;

  // texture select codes
  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_WEST  = 2'd2;
  localparam logic [1:0] TEX_EAST  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_CEILING_COLOR  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FLOOR_COLOR    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TEXTURE_HEIGHT = 2'd2;

  localparam logic [TH_W-1:0] TEX_H_RESET = 11'd64;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [LH_W-1:0]  slice_height;
    logic [TX_W-1:0]  texture_column;
    logic             hit_side;
    logic             dir_x_negative;
    logic             dir_y_negative;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]   out_column;
    logic [ROW_W-1:0]   out_row;
    logic [1:0]         region;
    logic [1:0]         texture_select;
    logic [TX_W-1:0]    texel_x;
    logic [TY_W-1:0]    texel_y;
    logic [COLOR_W-1:0] flat_color;
  } out_item_t;

  // Classified pixel, waiting for the texture row division.
  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [1:0]         region;
    logic [1:0]         texture_select;
    logic [TX_W-1:0]    texel_x;
    logic [COLOR_W-1:0] flat_color;
    logic [NUM_W-1:0]   num;
    logic [LH_W-1:0]    lh;
  } mid_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] ceiling_color;
    logic [COLOR_W-1:0] floor_color;
  } flat_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/raycast_wall_column_texel.sv =====
// Top level: configuration registers, classifying front end, pixel queue and divider back end.
//
//   channel  ports                          transfer when
//   input    push, full, in_data            push && !full
//   result   empty, pop, out_data           pop && !empty
//   config   cfg_we, cfg_index, cfg_wdata   cfg_we
//
// One pixel per cycle sustained in both directions while the consumer keeps popping results.
// From push to a visible result, the pixel enters the pixel queue at the accepting edge, then
// passes the product register, the texture row divider (11 stages, each adding a quotient bit)
// and the result queue. A stalled consumer freezes the divider pipeline once the two-entry result
// queue fills; the input keeps taking pixels until the four-entry pixel queue is full.
// Reset is synchronous; no clearing pass.
`default_nettype none

module raycast_wall_column_texel
  import rwct_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_data,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [COLOR_W-1:0] cfg_wdata
);

  flat_cfg_t       flat_cfg_r;
  logic [TH_W-1:0] tex_h_r;
  mid_item_t       mid;
  mid_item_t       q_data;
  logic            q_empty;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flat_cfg_r <= '0;
      tex_h_r    <= TEX_H_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CEILING_COLOR:  flat_cfg_r.ceiling_color <= cfg_wdata;
        CFG_FLOOR_COLOR:    flat_cfg_r.floor_color   <= cfg_wdata;
        CFG_TEXTURE_HEIGHT: tex_h_r                  <= cfg_wdata[TH_W-1:0];
        default: ;
      endcase
    end
  end

  rwct_front u_front (
    .item     (in_data),
    .flat_cfg (flat_cfg_r),
    .mid      (mid)
  );

  rwct_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (push),
    .wdata (mid),
    .full  (full),
    .rd    (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  rwct_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tex_h    (tex_h_r),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/rwct_front.sv =====
// Front end: classifies a pixel as ceiling, wall or floor and prepares the texture row numerator.
`default_nettype none

module rwct_front
  import rwct_pkg::*;
(
  input  in_item_t  item,
  input  flat_cfg_t flat_cfg,
  output mid_item_t mid
);

  logic [LH_W-1:0]  lh_eff;
  logic [POS_W-1:0] half_lh;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] end_sum;
  logic [POS_W-1:0] end_pos;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] twice_row_lh;
  logic             is_ceil;
  logic             is_wall;

  always_comb begin
    lh_eff  = (item.slice_height == '0) ? LH_W'(1) : item.slice_height;
    half_lh = POS_W'(lh_eff[LH_W-1:1]);

    start_pos = (half_lh >= POS_W'(HALF_H)) ? '0 : POS_W'(HALF_H) - half_lh;
    end_sum   = POS_W'(HALF_H) + half_lh;
    end_pos   = (end_sum > POS_W'(SCREEN_HEIGHT)) ? POS_W'(SCREEN_HEIGHT) : end_sum;

    row_pos = POS_W'(item.row);
    is_ceil = row_pos < start_pos;
    is_wall = !is_ceil && (row_pos < end_pos);

    // numerator 2*row - H + lh, kept only when positive
    twice_row_lh = POS_W'({item.row, 1'b0}) + POS_W'(lh_eff);

    mid = '0;
    mid.column = item.column;
    mid.row    = item.row;
    mid.lh     = lh_eff;
    if (is_ceil) begin
      mid.region     = REGION_CEIL;
      mid.flat_color = flat_cfg.ceiling_color;
    end else if (is_wall) begin
      mid.region  = REGION_WALL;
      mid.texel_x = item.texture_column;
      if (item.hit_side) begin
        mid.texture_select = item.dir_y_negative ? TEX_NORTH : TEX_SOUTH;
      end else begin
        mid.texture_select = item.dir_x_negative ? TEX_WEST : TEX_EAST;
      end
      if (twice_row_lh > POS_W'(SCREEN_HEIGHT)) begin
        mid.num = NUM_W'(twice_row_lh - POS_W'(SCREEN_HEIGHT));
      end
    end else begin
      mid.region     = REGION_FLOOR;
      mid.flat_color = flat_cfg.floor_color;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rwct_queue.sv =====
// Short queue of classified pixels between the front end and the divider pipeline.
`default_nettype none

module rwct_queue
  import rwct_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  mid_item_t wdata,
  output logic      full,
  input  logic      rd,
  output mid_item_t rdata,
  output logic      empty
);

  mid_item_t        mem_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wptr_r;
  logic [MQ_AW-1:0] rptr_r;
  logic [MQ_AW:0]   cnt_r;
  logic [MQ_AW:0]   cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full  = (cnt_r == (MQ_AW+1)'(MQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rwct_back.sv =====
// Back end: multiplier, bit-per-stage divider for the texture row, clamp and result queue.
`default_nettype none

module rwct_back
  import rwct_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [TH_W-1:0] tex_h,
  input  logic            q_empty,
  output logic            q_pop,
  input  mid_item_t       q_data,
  output logic            empty,
  input  logic            pop,
  output out_item_t       out_data
);

  // stage 0 holds the product, stage k holds k quotient bits
  out_item_t         meta_r [QW+1];
  logic [NUM_W-1:0]  rem_r  [QW+1];
  logic [QW-1:0]     low_r  [QW+1];
  logic [QW-1:0]     quo_r  [QW+1];
  logic [NUM_W-1:0]  den_r  [QW+1];
  logic [QW:0]       v_r;

  logic [NUM_W:0]    trial   [QW];
  logic              ge      [QW];
  logic [NUM_W-1:0]  rem_nxt [QW];

  logic [TH_W-1:0]   th_eff;
  logic [PROD_W-1:0] prod;
  out_item_t         meta_in;
  logic              adv;

  logic [TH_W-1:0]   q_clamp;
  out_item_t         res;

  out_item_t         ofifo_r [2];
  logic              owptr_r;
  logic              orptr_r;
  logic [1:0]        ocnt_r;
  logic              ofull;
  logic              ow;
  logic              orr;

  assign th_eff = (tex_h == '0) ? TH_W'(1) : tex_h;
  assign prod   = PROD_W'(q_data.num) * PROD_W'(th_eff);

  always_comb begin
    meta_in                = '0;
    meta_in.out_column     = q_data.column;
    meta_in.out_row        = q_data.row;
    meta_in.region         = q_data.region;
    meta_in.texture_select = q_data.texture_select;
    meta_in.texel_x        = q_data.texel_x;
    meta_in.flat_color     = q_data.flat_color;
  end

  assign ofull = (ocnt_r == 2'd2);
  assign adv   = !(v_r[QW] && ofull);
  assign q_pop = adv && !q_empty;

  // restoring division; remainder stays below the divisor
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k]   = {rem_r[k], low_r[k][QW-1]};
      ge[k]      = trial[k] >= {1'b0, den_r[k]};
      rem_nxt[k] = ge[k] ? NUM_W'(trial[k] - {1'b0, den_r[k]}) : trial[k][NUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[QW-1:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= meta_in;
      rem_r[0]  <= prod[PROD_W-1:QW];
      low_r[0]  <= prod[QW-1:0];
      quo_r[0]  <= '0;
      den_r[0]  <= {q_data.lh, 1'b0};
      for (int k = 0; k < QW; k++) begin
        meta_r[k+1] <= meta_r[k];
        rem_r[k+1]  <= rem_nxt[k];
        low_r[k+1]  <= {low_r[k][QW-2:0], 1'b0};
        quo_r[k+1]  <= {quo_r[k][QW-2:0], ge[k]};
        den_r[k+1]  <= den_r[k];
      end
    end
  end

  always_comb begin
    q_clamp = (quo_r[QW] >= th_eff) ? th_eff - 1'b1 : quo_r[QW];
    res     = meta_r[QW];
    if (meta_r[QW].region == REGION_WALL) begin
      res.texel_y = (q_clamp > TH_W'(TY_MAX)) ? TY_MAX : q_clamp[TY_W-1:0];
    end else begin
      res.texel_y = '0;
    end
  end

  // two-entry result queue decouples the pipeline from the consumer
  assign ow       = adv && v_r[QW];
  assign orr      = pop && !empty;
  assign empty    = (ocnt_r == 2'd0);
  assign out_data = ofifo_r[orptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= 1'b0;
      orptr_r <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      if (ow) begin
        owptr_r <= !owptr_r;
      end
      if (orr) begin
        orptr_r <= !orptr_r;
      end
      if (ow && !orr) begin
        ocnt_r <= ocnt_r + 2'd1;
      end else if (orr && !ow) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ow) begin
      ofifo_r[owptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rwct_checker.sv =====
// Checker: port-level properties of the raycast wall column texel block, bound to the top level.
`default_nettype none

module rwct_checker
  import rwct_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               push,
  input wire logic               full,
  input wire in_item_t           in_data,
  input wire logic               empty,
  input wire logic               pop,
  input wire out_item_t          out_data,
  input wire logic               cfg_we,
  input wire logic [CFG_IW-1:0]  cfg_index,
  input wire logic [COLOR_W-1:0] cfg_wdata
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result lost or changed");

  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.region == REGION_CEIL || out_data.region == REGION_WALL ||
                out_data.region == REGION_FLOOR))
    else $error("unused region code on output");

  a_flat_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.region != REGION_WALL) |->
      (out_data.texel_x == '0 && out_data.texel_y == '0 && out_data.texture_select == '0))
    else $error("texture fields set on a ceiling or floor pixel");

  a_wall_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.region == REGION_WALL) |-> (out_data.flat_color == '0))
    else $error("flat color set on a wall pixel");

endmodule

bind raycast_wall_column_texel rwct_checker u_rwct_checker (.*);

`default_nettype wire
